FILE: src/netpbm_stream_encoder_top_macros.svh
`ifndef NETPBM_STREAM_ENCODER_TOP_MACROS_SVH
`define NETPBM_STREAM_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NPBM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npbm check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define NPBM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npbm check failed");

`endif

FILE: src/npbm_pkg.sv
`timescale 1ns / 1ps

package npbm_pkg;

  // Dimensions
  localparam int unsigned MAX_DIM = 16384;
  localparam int DIM_W = 15;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM);

  // Format codes
  localparam logic [2:0] FMT_P1 = 3'd0;
  localparam logic [2:0] FMT_P2 = 3'd1;
  localparam logic [2:0] FMT_P3 = 3'd2;
  localparam logic [2:0] FMT_P4 = 3'd3;
  localparam logic [2:0] FMT_P5 = 3'd4;
  localparam logic [2:0] FMT_P6 = 3'd5;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // ASCII characters
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_2  = 8'h32;
  localparam logic [7:0] CH_5  = 8'h35;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0a;

  // Luma weights, dark threshold and divide-by-1000 reciprocal
  localparam int SUM_W = 18;
  localparam logic [SUM_W-1:0] W_RED      = 18'd299;
  localparam logic [SUM_W-1:0] W_GREEN    = 18'd587;
  localparam logic [SUM_W-1:0] W_BLUE     = 18'd114;
  localparam logic [SUM_W-1:0] DARK_LIMIT = 18'd128000;
  localparam logic [7:0]       PACK_MSB   = 8'd128;
  // ceil(2^28 / 1000); exact floor for every sum up to 255000
  localparam int RECIP_W = 19;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int GRAY_SHIFT = 28;
  localparam logic [RECIP_W-1:0] GRAY_RECIP = 19'd268436;

  // Decimal converter
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W = 4 * BCD_DIGITS;
  localparam int NARROW_BITS = 8;

  typedef enum logic [1:0] {
    TK_LIT,
    TK_RAW,
    TK_DEC
  } tok_kind_t;

  typedef enum logic [2:0] {
    SRC_W,
    SRC_H,
    SRC_R,
    SRC_G,
    SRC_B,
    SRC_GRAY,
    SRC_PACK
  } src_sel_t;

  typedef struct packed {
    tok_kind_t  kind;
    src_sel_t   src;
    logic [7:0] lit;
    logic       last;
  } token_t;

  typedef struct packed {
    logic             start;
    logic             narrow;
    logic [DIM_W-1:0] value;
  } dec_req_t;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
    logic [2:0]       ndig;
  } dec_rsp_t;

  typedef struct packed {
    logic       start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } luma_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] gray;
    logic       dark;
  } luma_rsp_t;

  // Unused format codes fall back to P6
  function automatic logic [2:0] fmt_norm(logic [2:0] fmt);
    return (fmt > FMT_P6) ? FMT_P6 : fmt;
  endfunction

  // Byte script: what to send at a given step of a header or pixel
  function automatic token_t tok_decode(logic hdr, logic [2:0] fmt, logic [3:0] step,
                                        logic dark, logic row_end);
    token_t     tok;
    logic [7:0] sep;
    sep      = row_end ? CH_LF : CH_SP;
    tok.kind = TK_LIT;
    tok.src  = SRC_R;
    tok.lit  = CH_LF;
    tok.last = 1'b1;
    if (hdr) begin
      case (step)
        4'd0: begin tok.lit = CH_P; tok.last = 1'b0; end
        4'd1: begin tok.lit = CH_1 + {5'd0, fmt}; tok.last = 1'b0; end
        4'd2: begin tok.lit = CH_LF; tok.last = 1'b0; end
        4'd3: begin tok.kind = TK_DEC; tok.src = SRC_W; tok.last = 1'b0; end
        4'd4: begin tok.lit = CH_SP; tok.last = 1'b0; end
        4'd5: begin tok.kind = TK_DEC; tok.src = SRC_H; tok.last = 1'b0; end
        4'd6: begin tok.lit = CH_LF; tok.last = (fmt == FMT_P1) || (fmt == FMT_P4); end
        4'd7: begin tok.lit = CH_2; tok.last = 1'b0; end
        4'd8: begin tok.lit = CH_5; tok.last = 1'b0; end
        4'd9: begin tok.lit = CH_5; tok.last = 1'b0; end
        default: begin tok.lit = CH_LF; tok.last = 1'b1; end
      endcase
    end else begin
      unique case (fmt)
        FMT_P1: begin
          if (step == 4'd0) begin
            tok.lit  = dark ? CH_1 : CH_0;
            tok.last = 1'b0;
          end else begin
            tok.lit = sep;
          end
        end
        FMT_P2: begin
          if (step == 4'd0) begin
            tok.kind = TK_DEC;
            tok.src  = SRC_GRAY;
            tok.last = 1'b0;
          end else begin
            tok.lit = sep;
          end
        end
        FMT_P3: begin
          case (step)
            4'd0: begin tok.kind = TK_DEC; tok.src = SRC_R; tok.last = 1'b0; end
            4'd1: begin tok.lit = CH_SP; tok.last = 1'b0; end
            4'd2: begin tok.kind = TK_DEC; tok.src = SRC_G; tok.last = 1'b0; end
            4'd3: begin tok.lit = CH_SP; tok.last = 1'b0; end
            4'd4: begin tok.kind = TK_DEC; tok.src = SRC_B; tok.last = 1'b0; end
            default: tok.lit = sep;
          endcase
        end
        FMT_P4: begin
          tok.kind = TK_RAW;
          tok.src  = SRC_PACK;
        end
        FMT_P5: begin
          tok.kind = TK_RAW;
          tok.src  = SRC_GRAY;
        end
        default: begin
          tok.kind = TK_RAW;
          case (step)
            4'd0: begin tok.src = SRC_R; tok.last = 1'b0; end
            4'd1: begin tok.src = SRC_G; tok.last = 1'b0; end
            default: tok.src = SRC_B;
          endcase
        end
      endcase
    end
    return tok;
  endfunction

endpackage

FILE: src/npbm_dec.sv
`timescale 1ns / 1ps

// Binary to BCD converter, one shift-and-adjust step per cycle
module npbm_dec
  import npbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dec_req_t req,
  output dec_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  logic [3:0]       cnt_r;
  logic [DIM_W-1:0] val_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;
  logic [2:0]       ndig;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  // Significant digits, at least one
  always_comb begin
    ndig = 3'd1;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) ndig = 3'(i + 1);
    end
  end

  // Iteration control; 8-bit values take the short path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.narrow ? 4'(NARROW_BITS) : 4'(DIM_W);
        val_r  <= req.narrow ? {req.value[NARROW_BITS-1:0], (DIM_W-NARROW_BITS)'(0)}
                             : req.value;
        bcd_r  <= '0;
      end else if (busy_r) begin
        bcd_r <= {adj[BCD_W-2:0], val_r[DIM_W-1]};
        val_r <= {val_r[DIM_W-2:0], 1'b0};
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.bcd  = bcd_r;
  assign rsp.ndig = ndig;

endmodule

FILE: src/npbm_luma.sv
`timescale 1ns / 1ps

// Luma: weighted sum, then divide by 1000 through a reciprocal multiply
module npbm_luma
  import npbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  luma_req_t req,
  output luma_rsp_t rsp
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_SUM  = 3'b010,
    L_DIV  = 3'b100
  } luma_state_t;

  luma_state_t       state_r;
  logic              done_r;
  logic              dark_r;
  logic [SUM_W-1:0]  prod_red_r;
  logic [SUM_W-1:0]  prod_green_r;
  logic [SUM_W-1:0]  prod_blue_r;
  logic [SUM_W-1:0]  sum_r;
  logic [7:0]        gray_r;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] scaled;

  assign sum    = prod_red_r + prod_green_r + prod_blue_r;
  assign scaled = PROD_W'(sum_r) * PROD_W'(GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        L_IDLE: begin
          if (req.start) begin
            prod_red_r   <= SUM_W'(req.red) * W_RED;
            prod_green_r <= SUM_W'(req.green) * W_GREEN;
            prod_blue_r  <= SUM_W'(req.blue) * W_BLUE;
            state_r      <= L_SUM;
          end
        end
        L_SUM: begin
          sum_r   <= sum;
          dark_r  <= sum < DARK_LIMIT;
          state_r <= L_DIV;
        end
        L_DIV: begin
          gray_r  <= scaled[GRAY_SHIFT +: 8];
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.gray = gray_r;
  assign rsp.dark = dark_r;

endmodule

FILE: src/netpbm_stream_encoder_top.sv
`timescale 1ns / 1ps
// Channel  | Dir | Transfer condition           | Contents
// in_      | in  | in_tvalid & in_tready        | tuser: opcode; tdata: red, green, blue
// out_     | out | out_tvalid & out_tready      | tdata: byte; tlast: last of run; tuser: frame end
// cfg_     | in  | psel & penable & pwrite      | format_select, frame_width, frame_height
//
// A pixel passes through the luma unit (products, sum, reciprocal multiply), then its bytes go
// out one by one as the output register frees; each decimal field also passes through the
// shared BCD converter (8 shift steps for a pixel field; header width and height take the full-width path).
// One item at a time: in_tready is high only in idle. A finished byte waits in the output
// register while the next item is taken. Reset is synchronous, active low.
`include "netpbm_stream_encoder_top_macros.svh"

module netpbm_stream_encoder_top
  import npbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic [0:0]  in_tuser,   // opcode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte [7:0]
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // frame_end [0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LUMA  = 5'b00010,
    S_TOKEN = 5'b00100,
    S_CONV  = 5'b01000,
    S_DIGIT = 5'b10000
  } seq_state_t;

  seq_state_t       state_r, state_nxt;
  logic [3:0]       step_r, step_nxt;
  logic [2:0]       dig_idx_r, dig_idx_nxt;

  logic [2:0]       format_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  logic [DIM_W-1:0] col_r;
  logic [DIM_W-1:0] row_r;
  logic [7:0]       pack_byte_r;
  logic [2:0]       pack_bits_r;
  logic [7:0]       pack_out_r;
  logic             frame_open_r;
  logic             hdr_r;
  logic             row_end_r;
  logic             fend_r;
  logic [7:0]       red_r;
  logic [7:0]       green_r;
  logic [7:0]       blue_r;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_fend_r;

  logic [2:0]       fmt_eff;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             in_acc;
  logic             cfg_wr;
  logic             row_end;
  logic             row_last;
  logic             out_free;
  logic [7:0]       pack_new;
  logic [2:0]       bits_new;
  token_t           tok;
  logic [DIM_W-1:0] src_val;
  logic [3:0]       digit;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             dec_start;
  dec_req_t         dec_req;
  dec_rsp_t         dec_rsp;
  luma_req_t        luma_req;
  luma_rsp_t        luma_rsp;

  // Shared units
  npbm_dec u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dec_req),
    .rsp   (dec_rsp)
  );

  npbm_luma u_luma (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (luma_req),
    .rsp   (luma_rsp)
  );

  // Effective settings
  assign fmt_eff = fmt_norm(format_r);
  assign w_eff   = (width_r > DIM_CAP) ? DIM_CAP : width_r;
  assign h_eff   = (height_r > DIM_CAP) ? DIM_CAP : height_r;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_P6;
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_FORMAT: format_r <= cfg_pwdata[2:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FORMAT: cfg_prdata = {29'd0, format_r};
      REG_WIDTH:  cfg_prdata = {17'd0, width_r};
      REG_HEIGHT: cfg_prdata = {17'd0, height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Input side and row/frame position
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign row_end   = ({1'b0, col_r} + 16'd1) >= {1'b0, w_eff};
  assign row_last  = ({1'b0, row_r} + 16'd1) >= {1'b0, h_eff};

  // P4 bit packing, MSB first
  assign pack_new = pack_byte_r | (luma_rsp.dark ? (PACK_MSB >> pack_bits_r) : 8'd0);
  assign bits_new = pack_bits_r + 3'd1;

  assign luma_req.start = in_acc && in_tuser[0] && frame_open_r;
  assign luma_req.red   = in_tdata[7:0];
  assign luma_req.green = in_tdata[15:8];
  assign luma_req.blue  = in_tdata[23:16];

  // Current script step
  assign tok = tok_decode(hdr_r, fmt_eff, step_r, luma_rsp.dark, row_end_r);

  always_comb begin
    case (tok.src)
      SRC_W:    src_val = w_eff;
      SRC_H:    src_val = h_eff;
      SRC_R:    src_val = DIM_W'(red_r);
      SRC_G:    src_val = DIM_W'(green_r);
      SRC_B:    src_val = DIM_W'(blue_r);
      SRC_GRAY: src_val = DIM_W'(luma_rsp.gray);
      SRC_PACK: src_val = DIM_W'(pack_out_r);
      default:  src_val = '0;
    endcase
  end

  assign dec_req.start  = dec_start;
  assign dec_req.narrow = !(tok.src == SRC_W || tok.src == SRC_H);
  assign dec_req.value  = src_val;
  assign digit          = dec_rsp.bcd[{dig_idx_r, 2'b00} +: 4];
  assign out_free       = !out_valid_r || out_tready;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    dig_idx_nxt = dig_idx_r;
    emit        = 1'b0;
    emit_byte   = tok.lit;
    emit_last   = 1'b0;
    dec_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          step_nxt = '0;
          if (!in_tuser[0]) state_nxt = S_TOKEN;
          else if (frame_open_r) state_nxt = S_LUMA;
        end
      end
      S_LUMA: begin
        if (luma_rsp.done) begin
          if (fmt_eff == FMT_P4 && !(bits_new == 3'd0 || row_end_r)) state_nxt = S_IDLE;
          else state_nxt = S_TOKEN;
        end
      end
      S_TOKEN: begin
        if (tok.kind == TK_DEC) begin
          dec_start = 1'b1;
          state_nxt = S_CONV;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_byte = (tok.kind == TK_LIT) ? tok.lit : src_val[7:0];
          emit_last = tok.last;
          if (tok.last) state_nxt = S_IDLE;
          else step_nxt = step_r + 4'd1;
        end
      end
      S_CONV: begin
        if (dec_rsp.done) begin
          dig_idx_nxt = dec_rsp.ndig - 3'd1;
          state_nxt   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = CH_0 + {4'd0, digit};
          emit_last = tok.last && (dig_idx_r == 3'd0);
          if (dig_idx_r == 3'd0) begin
            if (tok.last) begin
              state_nxt = S_IDLE;
            end else begin
              step_nxt  = step_r + 4'd1;
              state_nxt = S_TOKEN;
            end
          end else begin
            dig_idx_nxt = dig_idx_r - 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      dig_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      dig_idx_r <= dig_idx_nxt;
    end
  end

  // Frame position, P4 packing and per-item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      pack_byte_r  <= '0;
      pack_bits_r  <= '0;
      frame_open_r <= 1'b0;
      hdr_r        <= 1'b0;
      row_end_r    <= 1'b0;
      fend_r       <= 1'b0;
    end else begin
      if (in_acc && !in_tuser[0]) begin
        col_r        <= '0;
        row_r        <= '0;
        pack_byte_r  <= '0;
        pack_bits_r  <= '0;
        frame_open_r <= (w_eff != '0) && (h_eff != '0);
        fend_r       <= (w_eff == '0) || (h_eff == '0);
        hdr_r        <= 1'b1;
      end else if (in_acc && frame_open_r) begin
        hdr_r     <= 1'b0;
        red_r     <= in_tdata[7:0];
        green_r   <= in_tdata[15:8];
        blue_r    <= in_tdata[23:16];
        row_end_r <= row_end;
        fend_r    <= 1'b0;
        if (row_end) begin
          col_r <= '0;
          if (row_last) begin
            row_r        <= '0;
            frame_open_r <= 1'b0;
            fend_r       <= 1'b1;
          end else begin
            row_r <= row_r + DIM_W'(1);
          end
        end else begin
          col_r <= col_r + DIM_W'(1);
        end
      end
      if (state_r == S_LUMA && luma_rsp.done && fmt_eff == FMT_P4) begin
        if (bits_new == 3'd0 || row_end_r) begin
          pack_out_r  <= pack_new;
          pack_byte_r <= '0;
          pack_bits_r <= '0;
        end else begin
          pack_byte_r <= pack_new;
          pack_bits_r <= bits_new;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
      out_byte_r  <= emit_byte;
      out_last_r  <= emit_last;
      out_fend_r  <= emit_last && fend_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_fend_r;

  // Checks
  `NPBM_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_tready, !emit)
  `NPBM_ASSERT_IMP(a_fend_on_last, out_valid_r && out_fend_r, out_last_r)
  `NPBM_ASSERT_IMP(a_dec_done_in_conv, dec_rsp.done, state_r == S_CONV)
  `NPBM_ASSERT_NXT(a_luma_start_wait, luma_req.start, state_r == S_LUMA)

endmodule

FILE: tb/tb_netpbm_stream_encoder_top.sv
`timescale 1ns / 1ps

module tb_netpbm_stream_encoder_top
  import npbm_pkg::*;
;

  localparam int CLK_HALF = 10;
  // Covers the slowest item that ends without a byte (luma pass, pack step)
  // plus header decimal conversion, with margin.
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_LIMIT = 200000;
  localparam int STALL_CYCLES = 400;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;
  localparam logic [2:0] FMT_SPARE6 = 3'd6;
  localparam logic [2:0] FMT_SPARE7 = 3'd7;
  localparam int unsigned LUMA_DARK = 128000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fend;
  } enc_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic [0:0]  in_tuser;   // opcode [0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // out_byte [7:0]
  logic        out_tlast;
  logic [0:0]  out_tuser;  // frame_end [0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Encoder state as the testbench sees it
  logic [2:0]  enc_format;
  logic [14:0] enc_width;
  logic [14:0] enc_height;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [7:0]  pack_acc;
  int unsigned pack_fill;
  bit          frame_live;

  logic [7:0]  item_bytes[$];
  enc_byte_t   pending_bytes[$];

  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_reqs = 0;     // bumped by a test to ask for a hold-off
  int          hold_seen = 0;
  int          hold_cycles = 0;
  logic [23:0] px_at_limit;     // {r, g, b} with weighted sum exactly at the threshold
  logic [23:0] px_below_limit;  // {r, g, b} one below the threshold

  netpbm_stream_encoder_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Dimensions above the cap count as the cap
  function automatic int unsigned clamp_dim(logic [14:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic void append_decimal(int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CH_0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) item_bytes.push_back(digits[i]);
  endfunction

  // Bytes caused by one accepted item, queued with their run/frame flags
  function automatic void encode_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [2:0]  fmt;
    int unsigned w;
    int unsigned h;
    int unsigned sum;
    logic [7:0]  gray;
    logic [7:0]  sep;
    bit          dark;
    bit          row_end;
    bit          fend;
    bit          is_last;
    fmt = (enc_format > FMT_P6) ? FMT_P6 : enc_format;
    w = clamp_dim(enc_width);
    h = clamp_dim(enc_height);
    fend = 1'b0;
    item_bytes.delete();
    if (op == OP_START) begin
      col_pos = 0;
      row_pos = 0;
      pack_acc = '0;
      pack_fill = 0;
      item_bytes.push_back(CH_P);
      item_bytes.push_back(CH_1 + {5'd0, fmt});
      item_bytes.push_back(CH_LF);
      append_decimal(w);
      item_bytes.push_back(CH_SP);
      append_decimal(h);
      item_bytes.push_back(CH_LF);
      if (fmt != FMT_P1 && fmt != FMT_P4) begin
        item_bytes.push_back(CH_2);
        item_bytes.push_back(CH_5);
        item_bytes.push_back(CH_5);
        item_bytes.push_back(CH_LF);
      end
      frame_live = (w != 0) && (h != 0);
      fend = !frame_live;
    end else begin
      if (!frame_live) return;
      sum = 299 * r + 587 * g + 114 * b;
      gray = 8'(sum / 1000);
      dark = (sum < LUMA_DARK);
      row_end = (col_pos + 1 >= w);
      sep = row_end ? CH_LF : CH_SP;
      case (fmt)
        FMT_P1: begin
          item_bytes.push_back(dark ? CH_1 : CH_0);
          item_bytes.push_back(sep);
        end
        FMT_P2: begin
          append_decimal(gray);
          item_bytes.push_back(sep);
        end
        FMT_P3: begin
          append_decimal(r);
          item_bytes.push_back(CH_SP);
          append_decimal(g);
          item_bytes.push_back(CH_SP);
          append_decimal(b);
          item_bytes.push_back(sep);
        end
        FMT_P4: begin
          // dark pixels set bits MSB first; flush on a full byte or row end
          if (dark) pack_acc = pack_acc | (8'h80 >> pack_fill);
          pack_fill = (pack_fill + 1) % 8;
          if (pack_fill == 0 || row_end) begin
            item_bytes.push_back(pack_acc);
            pack_acc = '0;
            pack_fill = 0;
          end
        end
        FMT_P5: item_bytes.push_back(gray);
        default: begin
          item_bytes.push_back(r);
          item_bytes.push_back(g);
          item_bytes.push_back(b);
        end
      endcase
      if (row_end) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          frame_live = 1'b0;
          fend = 1'b1;
          row_pos = 0;
        end
      end else begin
        col_pos++;
      end
    end
    foreach (item_bytes[i]) begin
      is_last = (i == item_bytes.size() - 1);
      pending_bytes.push_back(enc_byte_t'{data: item_bytes[i], last: is_last,
                                          fend: is_last && fend});
    end
  endfunction

  // Some pixel whose weighted sum equals target
  function automatic logic [23:0] find_luma(int unsigned target);
    int rest;
    for (int gi = 0; gi < 256; gi++) begin
      for (int bi = 0; bi < 256; bi++) begin
        rest = int'(target) - 587 * gi - 114 * bi;
        if (rest >= 0 && rest % 299 == 0 && rest / 299 < 256)
          return {8'(rest / 299), 8'(gi), 8'(bi)};
      end
    end
    return 24'h808080;
  endfunction

  function automatic void rand_pixel(output logic [7:0] r, output logic [7:0] g,
                                     output logic [7:0] b);
    case ($urandom_range(9))
      0: {r, g, b} = px_at_limit;
      1: {r, g, b} = px_below_limit;
      2: {r, g, b} = $urandom_range(1) ? 24'hffffff : 24'h000000;
      default: {r, g, b} = 24'($urandom);
    endcase
  endfunction

  // One input transfer, with a random lead-in gap
  task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {b, g, r};
    do @(posedge clk); while (!in_tready);
    encode_item(op, r, g, b);
  endtask

  // Stop offering, let every queued byte arrive, then let the block settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_bytes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_FORMAT: enc_format = value[2:0];
      REG_WIDTH:  enc_width  = value[14:0];
      REG_HEIGHT: enc_height = value[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Settle, program all three registers and open a frame
  task automatic frame_with(input logic [2:0] fmt, input logic [14:0] w, input logic [14:0] h);
    wait_idle();
    cfg_write(REG_FORMAT, 32'(fmt));
    cfg_write(REG_WIDTH, 32'(w));
    cfg_write(REG_HEIGHT, 32'(h));
    send_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Reset values: P6, 0 x 0, pixels outside any frame are dropped
  task automatic test_reset_state();
    send_item(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    send_item(OP_START, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
  endtask

  task automatic test_every_format();
    frame_with(FMT_P1, 15'd1, 15'd1);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    frame_with(FMT_P2, 15'd1, 15'd1);
    send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    frame_with(FMT_P3, 15'd2, 15'd1);
    send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    frame_with(FMT_P5, 15'd1, 15'd1);
    send_item(OP_PIXEL, 8'hff, 8'h00, 8'h00);
    frame_with(FMT_P6, 15'd2, 15'd1);
    send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    // unused codes fall back to P6; zero width gives a header-only frame
    frame_with(FMT_SPARE6, 15'd1, 15'd1);
    send_item(OP_PIXEL, 8'h01, 8'h80, 8'hfe);
    frame_with(FMT_SPARE7, 15'd0, 15'd5);
  endtask

  // P4 row of nine: bits straddle the threshold, eighth pixel flushes a byte,
  // ninth flushes a padded one, the rest produce nothing
  task automatic test_luma_threshold();
    logic [23:0] px;
    frame_with(FMT_P4, 15'd9, 15'd1);
    for (int i = 0; i < 9; i++) begin
      px = (i % 3 == 1) ? px_at_limit : px_below_limit;
      send_item(OP_PIXEL, px[23:16], px[15:8], px[7:0]);
    end
  endtask

  // Saturated dimensions, empty frame and restart mid-frame
  task automatic test_dimension_limits();
    frame_with(FMT_P2, 15'h7fff, 15'd0);
    frame_with(FMT_P3, 15'd16384, 15'h7fff);
    send_item(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send_item(OP_START, 8'h00, 8'h00, 8'h00);
  endtask

  // Long receiver stall while the sender keeps offering
  task automatic test_output_stall();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    frame_with(FMT_P3, 15'd3, 15'd2);
    @(posedge clk);
    hold_reqs++;
    for (int i = 0; i < 6; i++) begin
      rand_pixel(r, g, b);
      send_item(OP_PIXEL, r, g, b);
    end
  endtask

  // Mostly whole frames with random content; some truncated, overrun,
  // reconfigured mid-frame, or preceded by a stray pixel
  task automatic test_random_frames(input int target);
    int          sent;
    int          npix;
    int          roll;
    logic [2:0]  fmt;
    logic [14:0] w;
    logic [14:0] h;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    bit          huge;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 70) begin
        fmt = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        roll = $urandom_range(19);
        if (roll == 0) begin
          w = 15'($urandom_range(16384, 32767));
          h = 15'($urandom_range(32767));
        end else if (roll == 1) begin
          w = $urandom_range(1) ? 15'd0 : 15'($urandom_range(1, 8));
          h = (w == 0) ? 15'($urandom_range(3)) : 15'd0;
        end else begin
          w = 15'($urandom_range(1, (fmt == FMT_P4) ? 20 : 8));
          h = 15'($urandom_range(1, 3));
        end
        frame_with(fmt, w, h);
      end else begin
        if ($urandom_range(99) < 5) begin
          rand_pixel(r, g, b);
          send_item(OP_PIXEL, r, g, b);
        end
        rand_pixel(r, g, b);
        send_item(OP_START, r, g, b);
      end
      sent++;
      huge = (enc_width > 64) || (enc_height > 64);
      if (huge) npix = $urandom_range(3);
      else npix = clamp_dim(enc_width) * clamp_dim(enc_height);
      roll = $urandom_range(99);
      if (roll < 10 && npix > 0) npix = $urandom_range(npix - 1);
      else if (roll < 20) npix += $urandom_range(1, 2);
      for (int i = 0; i < npix; i++) begin
        if (!huge && $urandom_range(99) < 3) begin
          wait_idle();
          case ($urandom_range(2))
            0: cfg_write(REG_FORMAT, 32'($urandom_range(5)));
            1: cfg_write(REG_WIDTH, 32'($urandom_range(1, 8)));
            default: cfg_write(REG_HEIGHT, 32'($urandom_range(1, 3)));
          endcase
        end
        rand_pixel(r, g, b);
        if (frame_live) sent++;
        send_item(OP_PIXEL, r, g, b);
      end
    end
  endtask

  // Receiver: random ready, or a counted hold-off
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_cycles <= STALL_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every output transfer against the oldest queued byte
  always @(posedge clk) begin
    enc_byte_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output byte %02h", out_tdata);
        err_count++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_tdata !== exp_b.data) begin
          $error("out_byte: expected %02h, got %02h", exp_b.data, out_tdata);
          err_count++;
        end
        if (out_tlast !== exp_b.last) begin
          $error("last_of_run: expected %0b, got %0b", exp_b.last, out_tlast);
          err_count++;
        end
        if (out_tuser[0] !== exp_b.fend) begin
          $error("frame_end: expected %0b, got %0b", exp_b.fend, out_tuser[0]);
          err_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL netpbm_stream_encoder_top");
    $finish;
  end

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    enc_format  = FMT_P6;
    enc_width   = '0;
    enc_height  = '0;
    col_pos     = 0;
    row_pos     = 0;
    pack_acc    = '0;
    pack_fill   = 0;
    frame_live  = 1'b0;
    px_at_limit    = find_luma(LUMA_DARK);
    px_below_limit = find_luma(LUMA_DARK - 1);
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 48;
    test_reset_state();
    test_every_format();
    test_luma_threshold();
    test_dimension_limits();
    test_output_stall();
    test_random_frames(120);

    send_idle_pct = 48;
    recv_idle_pct = 23;
    test_random_frames(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(110);

    wait_idle();
    if (pending_bytes.size() != 0) begin
      $error("%0d expected output bytes never arrived", pending_bytes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS netpbm_stream_encoder_top");
    end else begin
      $display("FAIL netpbm_stream_encoder_top");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/npbm_pkg.sv
src/npbm_dec.sv
src/npbm_luma.sv
src/netpbm_stream_encoder_top.sv
tb/tb_netpbm_stream_encoder_top.sv
